@@ src/lzsshc_pkg.sv @@
// Package: shared types, constants and state codes for the LZSS compressor.
`default_nettype none
package lzsshc_pkg;

	localparam int WINDOW_SIZE_DEF   = 4096;
	localparam int HASH_BUCKETS_DEF  = 4096;
	localparam int LOOKAHEAD_MAX_DEF = 18;
	localparam int POSITION_BITS_DEF = 32;

	localparam int MIN_LEN      = 3;
	localparam int CHAIN_CAP    = 256;
	localparam int GROUP_TOKENS = 8;
	localparam int GROUP_DEPTH  = 17;

	typedef struct packed {
		logic [7:0] raw_byte;
		logic       stream_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       run_last;
		logic       stream_end;
	} out_word_t;

	// command from the sequencer to the output stage
	typedef struct packed {
		logic       push;
		logic       fin;
		logic       end_flag;
		logic [7:0] byte_val;
	} out_cmd_t;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_LOOP,
		ST_DEC,
		ST_DECS,
		ST_F0,
		ST_F1,
		ST_F2,
		ST_F3,
		ST_NODE,
		ST_CAND,
		ST_CISS,
		ST_CCHK,
		ST_CEND,
		ST_SDONE,
		ST_EMIT,
		ST_FIN,
		ST_FIN2
	} state_t;

endpackage
`default_nettype wire

@@ src/lzsshc_out.sv @@
// Output stage: holds one pending byte so the last byte of an item can be marked.
`default_nettype none
module lzsshc_out
	import lzsshc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire out_cmd_t  cmd,
	output logic           ok,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_word
);

	logic       pend_v_q;
	logic [7:0] pend_q;
	logic       out_v_q;
	out_word_t  out_q;
	logic       free;

	assign free      = !out_v_q || out_ready;
	assign ok        = !pend_v_q || free;
	assign out_valid = out_v_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else if (cmd.push && ok) begin
			if (pend_v_q) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			pend_v_q <= 1'b1;
		end else if (cmd.fin && ok && pend_v_q) begin
			out_v_q  <= 1'b1;
			pend_v_q <= 1'b0;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && ok) begin
			if (pend_v_q) begin
				out_q <= '{packed_byte: pend_q, run_last: 1'b0, stream_end: 1'b0};
			end
			pend_q <= cmd.byte_val;
		end else if (cmd.fin && ok && pend_v_q) begin
			out_q <= '{packed_byte: pend_q, run_last: 1'b1, stream_end: cmd.end_flag};
		end
	end

endmodule
`default_nettype wire

@@ src/lzss_hash_chain_compressor_top.sv @@
// Top level: LZSS compressor with hash-chain match search under one sequencer.
// An item that only fills the lookahead passes from accept back to ready without a search;
// a token decision walks the hash chain entry by entry (up to chain_limit,
// at most 256) and, for an entry in the window, compares byte by byte (up to 18);
// skipped match bytes are retired one at a time; bytes are emitted while the output is free.
// Reset and every stream end run a clearing pass over the match tables with in_ready low.
`default_nettype none
module lzss_hash_chain_compressor_top
	import lzsshc_pkg::*;
#(
	parameter int WINDOW_SIZE   = WINDOW_SIZE_DEF,
	parameter int HASH_BUCKETS  = HASH_BUCKETS_DEF,
	parameter int LOOKAHEAD_MAX = LOOKAHEAD_MAX_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire in_word_t   in_word,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_word_t       out_word,
	input  wire logic       cfg_we,
	input  wire logic [8:0] cfg_data
);

	// window and bucket counts are powers of two
	localparam int AW   = $clog2(WINDOW_SIZE);
	localparam int HW   = $clog2(HASH_BUCKETS);
	localparam int NW   = AW + 1;
	localparam int LAW  = $clog2(LOOKAHEAD_MAX);
	localparam int LCW  = $clog2(LOOKAHEAD_MAX + 1);
	localparam int PB   = POSITION_BITS;
	localparam int CLRN = (WINDOW_SIZE > HASH_BUCKETS) ? WINDOW_SIZE : HASH_BUCKETS;
	localparam int CW   = $clog2(CLRN);

	localparam logic [PB-1:0]  POS_NONE = {PB{1'b1}};
	localparam logic [LCW-1:0] LA_N     = LCW'(LOOKAHEAD_MAX);
	localparam logic [LCW-1:0] MIN_N    = LCW'(MIN_LEN);

	function automatic logic [LAW-1:0] la_wrap(input logic [LAW-1:0] base,
		input logic [LCW-1:0] k);
		logic [LCW:0] s;
		s = (LCW+1)'(base) + (LCW+1)'(k);
		if (s >= (LCW+1)'(LOOKAHEAD_MAX)) begin
			s = s - (LCW+1)'(LOOKAHEAD_MAX);
		end
		return s[LAW-1:0];
	endfunction

	// ---------------- storage ----------------
	logic [7:0]    hist_mem  [WINDOW_SIZE];
	logic [NW-1:0] heads_mem [HASH_BUCKETS];
	logic [NW-1:0] links_mem [WINDOW_SIZE];
	logic [PB-1:0] spos_mem  [WINDOW_SIZE];
	logic [7:0]    la_mem    [LOOKAHEAD_MAX];
	logic [7:0]    gbuf_q    [GROUP_DEPTH];

	// ---------------- control registers ----------------
	state_t         state_q, state_d;
	logic [8:0]     chain_limit_q;
	logic [LAW-1:0] head_q;
	logic [LCW-1:0] cnt_q;
	logic [PB-1:0]  pos_q;
	logic [4:0]     glen_q;
	logic [3:0]     tc_q;
	logic [7:0]     flags_q;
	logic [LCW-1:0] skip_q;
	logic           last_q;
	logic           mode_q;      // 0 = fetch for search, 1 = fetch for insert
	logic           eret_q;      // 0 = back to search, 1 = back to finish
	logic [4:0]     eidx_q;
	logic [CW-1:0]  clr_q;
	logic [8:0]     tries_q;
	logic [NW-1:0]  node_q;
	logic [PB-1:0]  cpos_q;
	logic [AW-1:0]  dist_q;
	logic [AW-1:0]  bdist_q;
	logic [LCW-1:0] best_q;
	logic [LCW-1:0] j_q;
	logic           sel_q;
	logic [7:0]     f0_q, f1_q;
	logic [HW-1:0]  hash_q;

	// memory read data
	logic [7:0]    hist_rd, la_a_rd, la_b_rd;
	logic [NW-1:0] heads_rd, links_rd;
	logic [PB-1:0] spos_rd;

	// ---------------- combinational helpers ----------------
	logic [8:0]     lim;
	logic           in_acc;
	logic           loop_go;
	logic [15:0]    hv;
	logic [HW-1:0]  hash_w;
	logic [AW-1:0]  wslot;
	logic [NW-1:0]  nm1;
	logic [AW-1:0]  cslot;
	logic [PB-1:0]  cdist;
	logic           cand_ok;
	logic [7:0]     src;
	logic           cmp_eq;
	logic [11:0]    d12;
	logic [LCW-1:0] lenm3;
	logic [LCW-1:0] jk;
	logic           ins_now, cons_now;
	logic [7:0]     ebyte;
	logic           out_ok;
	out_cmd_t       cmd;

	// memory port controls
	logic [LAW-1:0] la_a_addr, la_b_addr;
	logic [AW-1:0]  hist_raddr;
	logic [HW-1:0]  heads_raddr;
	logic           clr_heads, clr_win;

	assign lim     = (chain_limit_q > 9'(CHAIN_CAP)) ? 9'(CHAIN_CAP) : chain_limit_q;
	assign in_acc  = in_valid && in_ready;
	assign loop_go = (cnt_q != '0) && ((cnt_q >= LA_N) || last_q);
	assign hv      = (16'(f0_q) * 16'd251) ^ (16'(f1_q) * 16'd31) ^ 16'(la_a_rd);
	assign hash_w  = hv[HW-1:0];
	assign wslot   = pos_q[AW-1:0];
	assign nm1     = node_q - 1'b1;
	assign cslot   = nm1[AW-1:0];
	assign cdist   = pos_q - spos_rd;
	assign cand_ok = (spos_rd != POS_NONE) && (spos_rd < pos_q)
		&& (cdist <= PB'(WINDOW_SIZE - 1));
	assign src     = sel_q ? hist_rd : la_a_rd;
	assign cmp_eq  = (src == la_b_rd);
	assign d12     = 12'(bdist_q);
	assign lenm3   = best_q - MIN_N;
	assign jk      = (LCW'(j_q) >= LCW'(dist_q[LCW-1:0]) && (AW'(j_q) >= dist_q))
		? (j_q - dist_q[LCW-1:0]) : '0;
	assign ins_now  = (state_q == ST_F3) && mode_q;
	assign cons_now = ins_now || ((state_q == ST_F2) && mode_q && (cnt_q < MIN_N));
	assign ebyte    = (eidx_q == '0) ? flags_q : gbuf_q[eidx_q];
	assign clr_heads = (state_q == ST_CLR) && (32'(clr_q) < HASH_BUCKETS);
	assign clr_win   = (state_q == ST_CLR) && (32'(clr_q) < WINDOW_SIZE);

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				if (32'(clr_q) == CLRN - 1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc) state_d = ST_LOOP;
			end
			ST_LOOP: begin
				if (!loop_go) state_d = ST_FIN;
				else if (skip_q != '0) state_d = ST_F0;
				else state_d = ST_DEC;
			end
			ST_DEC: begin
				state_d = (tc_q >= 4'(GROUP_TOKENS)) ? ST_EMIT : ST_DECS;
			end
			ST_DECS: state_d = ST_F0;
			ST_F0:   state_d = ST_F1;
			ST_F1:   state_d = ST_F2;
			ST_F2: begin
				if (cnt_q < MIN_N) state_d = mode_q ? ST_LOOP : ST_SDONE;
				else state_d = ST_F3;
			end
			ST_F3: state_d = mode_q ? ST_LOOP : ST_NODE;
			ST_NODE: begin
				state_d = ((node_q == '0) || (tries_q >= lim)) ? ST_SDONE : ST_CAND;
			end
			ST_CAND: state_d = cand_ok ? ST_CISS : ST_NODE;
			ST_CISS: begin
				state_d = ((j_q >= cnt_q) || (j_q >= LA_N)) ? ST_CEND : ST_CCHK;
			end
			ST_CCHK: state_d = cmp_eq ? ST_CISS : ST_CEND;
			ST_CEND: begin
				if ((j_q > best_q) && ((j_q == cnt_q) || (j_q == LA_N))) state_d = ST_SDONE;
				else state_d = ST_NODE;
			end
			ST_SDONE: state_d = ST_F0;
			ST_EMIT: begin
				if (out_ok && (eidx_q == glen_q - 5'd1)) state_d = eret_q ? ST_FIN2 : ST_DECS;
			end
			ST_FIN: begin
				state_d = (last_q && (tc_q != '0)) ? ST_EMIT : ST_FIN2;
			end
			ST_FIN2: begin
				if (out_ok) state_d = last_q ? ST_CLR : ST_IDLE;
			end
			default: state_d = ST_CLR;
		endcase
	end

	// ---------------- outputs of the sequencer ----------------
	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		la_a_addr   = la_wrap(head_q, '0);
		la_b_addr   = la_wrap(head_q, LCW'(1));
		hist_raddr  = cpos_q[AW-1:0] + AW'(j_q);
		heads_raddr = hash_w;
		cmd         = '0;
		case (state_q)
			ST_F1: la_a_addr = la_wrap(head_q, LCW'(2));
			ST_CISS: begin
				la_a_addr = la_wrap(head_q, jk);
				la_b_addr = la_wrap(head_q, j_q);
			end
			ST_EMIT: begin
				cmd.push     = 1'b1;
				cmd.byte_val = ebyte;
			end
			ST_FIN2: begin
				cmd.fin      = 1'b1;
				cmd.end_flag = last_q;
			end
			default: ;
		endcase
	end

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		if (in_acc && (cnt_q < LA_N)) la_mem[la_wrap(head_q, cnt_q)] <= in_word.raw_byte;
		la_a_rd <= la_mem[la_a_addr];
		la_b_rd <= la_mem[la_b_addr];
	end

	always_ff @(posedge clk) begin
		if (cons_now) hist_mem[wslot] <= f0_q;
		hist_rd <= hist_mem[hist_raddr];
	end

	always_ff @(posedge clk) begin
		if (clr_heads) heads_mem[clr_q[HW-1:0]] <= '0;
		else if (ins_now) heads_mem[hash_q] <= NW'(wslot) + 1'b1;
		heads_rd <= heads_mem[heads_raddr];
	end

	always_ff @(posedge clk) begin
		if (clr_win) links_mem[clr_q[AW-1:0]] <= '0;
		else if (ins_now) links_mem[wslot] <= heads_rd;
		links_rd <= links_mem[cslot];
	end

	always_ff @(posedge clk) begin
		if (clr_win) spos_mem[clr_q[AW-1:0]] <= POS_NONE;
		else if (ins_now) spos_mem[wslot] <= pos_q;
		spos_rd <= spos_mem[cslot];
	end

	// ---------------- control state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR;
			chain_limit_q <= 9'(CHAIN_CAP);
			head_q        <= '0;
			cnt_q         <= '0;
			pos_q         <= '0;
			glen_q        <= 5'd1;
			tc_q          <= '0;
			flags_q       <= '0;
			skip_q        <= '0;
			last_q        <= 1'b0;
			mode_q        <= 1'b0;
			eret_q        <= 1'b0;
			eidx_q        <= '0;
			clr_q         <= '0;
			tries_q       <= '0;
			node_q        <= '0;
			best_q        <= '0;
			j_q           <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) chain_limit_q <= cfg_data;
			// advance the lookahead ring on every consumed byte
			if (cons_now) begin
				head_q <= la_wrap(head_q, LCW'(1));
				cnt_q  <= cnt_q - 1'b1;
				pos_q  <= pos_q + 1'b1;
			end
			case (state_q)
				ST_CLR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					if (in_acc) begin
						last_q <= in_word.stream_last;
						if (cnt_q < LA_N) cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_LOOP: begin
					if (loop_go && (skip_q != '0)) begin
						skip_q <= skip_q - 1'b1;
						mode_q <= 1'b1;
					end
				end
				ST_DEC: begin
					eret_q <= 1'b0;
					eidx_q <= '0;
				end
				ST_DECS: begin
					mode_q  <= 1'b0;
					best_q  <= '0;
					tries_q <= '0;
				end
				ST_F3: begin
					if (!mode_q) node_q <= heads_rd;
				end
				ST_NODE: begin
					if ((node_q != '0) && (tries_q < lim)) tries_q <= tries_q + 1'b1;
				end
				ST_CAND: begin
					node_q <= links_rd;
					j_q    <= '0;
				end
				ST_CCHK: begin
					if (cmp_eq) j_q <= j_q + 1'b1;
				end
				ST_CEND: begin
					if (j_q > best_q) best_q <= j_q;
				end
				ST_SDONE: begin
					mode_q <= 1'b1;
					tc_q   <= tc_q + 1'b1;
					if (best_q >= MIN_N) begin
						glen_q <= glen_q + 5'd2;
						skip_q <= best_q - 1'b1;
					end else begin
						glen_q  <= glen_q + 5'd1;
						flags_q <= flags_q | (8'd1 << tc_q[2:0]);
					end
				end
				ST_EMIT: begin
					if (out_ok) begin
						eidx_q <= eidx_q + 5'd1;
						if (eidx_q == glen_q - 5'd1) begin
							glen_q  <= 5'd1;
							tc_q    <= '0;
							flags_q <= '0;
						end
					end
				end
				ST_FIN: begin
					eret_q <= 1'b1;
					eidx_q <= '0;
				end
				ST_FIN2: begin
					// drop the match tables and counters at stream end
					if (out_ok && last_q) begin
						clr_q   <= '0;
						head_q  <= '0;
						cnt_q   <= '0;
						pos_q   <= '0;
						glen_q  <= 5'd1;
						tc_q    <= '0;
						flags_q <= '0;
						skip_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_F1: begin
				f0_q <= la_a_rd;
				f1_q <= la_b_rd;
			end
			ST_F2: hash_q <= hash_w;
			ST_CAND: begin
				cpos_q <= spos_rd;
				dist_q <= cdist[AW-1:0];
			end
			ST_CISS: sel_q <= (AW'(j_q) < dist_q);
			ST_CEND: begin
				if (j_q > best_q) bdist_q <= dist_q;
			end
			ST_DECS: bdist_q <= '0;
			ST_SDONE: begin
				if (best_q >= MIN_N) begin
					gbuf_q[glen_q]        <= d12[7:0];
					gbuf_q[glen_q + 5'd1] <= {d12[11:8], 4'(lenm3)};
				end else begin
					gbuf_q[glen_q] <= f0_q;
				end
			end
			default: ;
		endcase
	end

	lzsshc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ok        (out_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule
`default_nettype wire

@@ sim/tb_lzss_hash_chain_compressor_top.sv @@
// Testbench for the LZSS hash-chain compressor: self-predicting, randomized, self-checking.
`timescale 1ns / 100ps
`default_nettype none
module tb_lzss_hash_chain_compressor_top
	import lzsshc_pkg::*;
;

	localparam int WIN       = 4096;
	localparam int BUCKETS   = 4096;
	localparam int LA_MAX    = 18;
	localparam int HOLD_LEN  = 400;
	localparam int CYCLE_CAP = 40000000;
	localparam logic [31:0] POS_NONE = 32'hFFFF_FFFF;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_word_t   in_word;
	logic       out_valid;
	logic       out_ready;
	out_word_t  out_word;
	logic       cfg_we;
	logic [8:0] cfg_data;

	lzss_hash_chain_compressor_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// Shadow copy of the compressor state, kept in step with accepted words.
	logic [7:0]  win_bytes [WIN];
	int unsigned bucket_top [BUCKETS];
	int unsigned chain_next [WIN];
	logic [31:0] slot_stamp [WIN];
	logic [7:0]  ahead [LA_MAX];
	int unsigned ahead_n;
	logic [31:0] stream_pos;
	logic [7:0]  grp_bytes [17];
	int unsigned grp_n;
	int unsigned tok_n;
	logic [7:0]  flag_acc;
	int unsigned skip_n;
	logic [8:0]  chain_lim;

	out_word_t   packed_q[$];   // compressed bytes still to come, oldest first
	logic [7:0]  step_bytes[$]; // bytes produced by the word being predicted
	int          fail_count;
	int unsigned cycle_count;
	bit          idle_on;
	bit          hold_req;

	// ---------------------------------------------------------------- clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Abort the run if the pipeline hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("%0t timeout waiting for compressed output", $time);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------ predictor
	function automatic int unsigned front_hash();
		int unsigned v;
		v = (int'(ahead[0]) * 251) ^ (int'(ahead[1]) * 31) ^ int'(ahead[2]);
		return v % BUCKETS;
	endfunction

	task automatic wipe_tables();
		for (int i = 0; i < BUCKETS; i++)
			bucket_top[i] = 0;
		for (int i = 0; i < WIN; i++) begin
			chain_next[i] = 0;
			slot_stamp[i] = POS_NONE;
		end
		ahead_n    = 0;
		stream_pos = '0;
		grp_n      = 1;
		tok_n      = 0;
		flag_acc   = '0;
		skip_n     = 0;
	endtask

	// Retire the front lookahead byte into the window, hashing it if at least 3 bytes remain.
	task automatic retire_front();
		int unsigned slot;
		int unsigned h;
		slot = stream_pos % WIN;
		if (ahead_n == 0)
			return;
		if (ahead_n >= MIN_LEN) begin
			h = front_hash();
			chain_next[slot] = bucket_top[h];
			bucket_top[h]    = slot + 1;
			slot_stamp[slot] = stream_pos;
		end
		win_bytes[slot] = ahead[0];
		for (int i = 1; i < ahead_n; i++)
			ahead[i - 1] = ahead[i];
		ahead_n--;
		stream_pos = stream_pos + 1;
	endtask

	task automatic longest_match(output int unsigned best, output logic [31:0] match_gap);
		int unsigned lim;
		int unsigned tries;
		int unsigned node;
		int unsigned slot;
		int unsigned j;
		logic [31:0] cpos;
		logic [31:0] cand_gap;
		logic [7:0]  src;
		lim       = (chain_lim > CHAIN_CAP) ? CHAIN_CAP : chain_lim;
		tries     = 0;
		best      = 0;
		match_gap = '0;
		if (ahead_n < MIN_LEN)
			return;
		node = bucket_top[front_hash()];
		while (node != 0 && tries < lim) begin
			slot = (node - 1) % WIN;
			cpos = slot_stamp[slot];
			tries++;
			node = chain_next[slot];
			if (cpos == POS_NONE || cpos >= stream_pos)
				continue;
			cand_gap = stream_pos - cpos;
			if (cand_gap > WIN - 1)
				continue;
			for (j = 0; j < ahead_n && j < LA_MAX; j++) begin
				if (j < cand_gap)
					src = win_bytes[(cpos + j) % WIN];
				else
					src = ahead[(j - cand_gap) % LA_MAX];
				if (src != ahead[j])
					break;
			end
			if (j > best) begin
				best      = j;
				match_gap = cand_gap;
				if (best == ahead_n || best == LA_MAX)
					break;
			end
		end
	endtask

	task automatic flush_group();
		grp_bytes[0] = flag_acc;
		for (int i = 0; i < grp_n && i < 17; i++)
			step_bytes.push_back(grp_bytes[i]);
		grp_n    = 1;
		tok_n    = 0;
		flag_acc = '0;
	endtask

	task automatic code_token();
		int unsigned len;
		logic [31:0] m_gap;
		if (tok_n >= GROUP_TOKENS)
			flush_group();
		longest_match(len, m_gap);
		if (len >= MIN_LEN) begin
			grp_bytes[grp_n++] = m_gap[7:0];
			grp_bytes[grp_n++] = {m_gap[11:8], 4'(len - MIN_LEN)};
			retire_front();
			skip_n = len - 1;
		end else begin
			flag_acc[tok_n]    = 1'b1;
			grp_bytes[grp_n++] = ahead[0];
			retire_front();
		end
		tok_n++;
	endtask

	// Queue every compressed byte that one accepted word produces.
	task automatic predict_word(input in_word_t w);
		out_word_t o;
		step_bytes.delete();
		if (ahead_n < LA_MAX)
			ahead[ahead_n++] = w.raw_byte;
		while (ahead_n > 0 && (ahead_n >= LA_MAX || w.stream_last)) begin
			if (skip_n > 0) begin
				retire_front();
				skip_n--;
			end else begin
				code_token();
			end
		end
		if (w.stream_last) begin
			if (tok_n > 0)
				flush_group();
			wipe_tables();
		end
		foreach (step_bytes[i]) begin
			o.packed_byte = step_bytes[i];
			o.run_last    = (i == step_bytes.size() - 1);
			o.stream_end  = w.stream_last && (i == step_bytes.size() - 1);
			packed_q.push_back(o);
		end
	endtask

	// --------------------------------------------------------------- checker
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (packed_q.size() == 0) begin
				$display("%0t unexpected word: expected none, actual %h", $time, out_word);
				fail_count++;
			end else begin
				want = packed_q.pop_front();
				if (out_word.packed_byte !== want.packed_byte) begin
					$display("%0t packed_byte: expected %h actual %h", $time,
						want.packed_byte, out_word.packed_byte);
					fail_count++;
				end
				if (out_word.run_last !== want.run_last) begin
					$display("%0t run_last: expected %b actual %b", $time,
						want.run_last, out_word.run_last);
					fail_count++;
				end
				if (out_word.stream_end !== want.stream_end) begin
					$display("%0t stream_end: expected %b actual %b", $time,
						want.stream_end, out_word.stream_end);
					fail_count++;
				end
			end
		end
	end

	// --------------------------------------------------------------- receiver
	// Stall in random bursts; on request hold off long enough to back up the block.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 11) - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// ----------------------------------------------------------------- sender
	// Offer one word and hold it until accepted, then advance the prediction.
	task automatic send_word(input logic [7:0] b, input logic lst);
		in_word_t w;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		w.raw_byte    = b;
		w.stream_last = lst;
		in_word  = w;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_word(w);
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Send a stream built to hit the match finder: repeats, copies, or noise.
	task automatic send_stream(input int unsigned len);
		logic [7:0] body[$];
		int unsigned style;
		int unsigned back;
		logic [7:0]  b;
		style = $urandom_range(0, 9);
		for (int i = 0; i < len; i++) begin
			if (style < 4)
				b = 8'($urandom_range(0, 3)) ^ (style == 0 ? 8'hFF : 8'h00);
			else if (style < 8 && body.size() > 3 && $urandom_range(0, 5) != 0) begin
				back = $urandom_range(1, body.size() < 40 ? body.size() : 40);
				b = body[body.size() - back];
			end else
				b = 8'($urandom);
			body.push_back(b);
			send_word(b, i == len - 1);
		end
		drop_valid();
	endtask

	// Change the search bound only once every expected byte is out.
	task automatic set_chain_limit(input logic [8:0] v);
		wait (packed_q.size() == 0);
		repeat (200) @(negedge clk);
		cfg_data  = v;
		cfg_we    = 1'b1;
		chain_lim = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// ------------------------------------------------------------------ tests
	task automatic test_short_streams();
		send_word(8'hFF, 1'b1);
		send_word(8'h00, 1'b0);
		send_word(8'h80, 1'b1);
		send_word(8'h41, 1'b0);
		send_word(8'h42, 1'b0);
		send_word(8'h43, 1'b1);
		drop_valid();
	endtask

	// Long runs reach full-length matches that overlap the lookahead.
	task automatic test_runs();
		for (int i = 0; i < 20; i++)
			send_word(8'h00, i == 19);
		drop_valid();
	endtask

	task automatic test_chain_limits();
		logic [8:0] lims[7] = '{9'd1, 9'd0, 9'd511, 9'd8, 9'd300, 9'd2, 9'd256};
		foreach (lims[k]) begin
			set_chain_limit(lims[k]);
			repeat (2) send_stream($urandom_range(10, 30));
		end
		set_chain_limit(9'($urandom_range(1, 256)));
		send_stream($urandom_range(10, 30));
	endtask

	// Hold the receiver off while words keep coming in.
	task automatic test_backpressure();
		hold_req = 1'b1;
		send_stream(60);
	endtask

	task automatic test_no_idle();
		wait (packed_q.size() == 0);
		idle_on = 1'b0;
		send_stream(40);
		send_stream(20);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_word     = '0;
		cfg_we      = 1'b0;
		cfg_data    = 9'd0;
		fail_count  = 0;
		cycle_count = 0;
		idle_on     = 1'b1;
		hold_req    = 1'b0;
		chain_lim   = 9'(CHAIN_CAP);
		for (int i = 0; i < WIN; i++)
			win_bytes[i] = '0;
		wipe_tables();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_short_streams();
		test_runs();
		test_chain_limits();
		test_backpressure();
		test_no_idle();

		wait (packed_q.size() == 0);
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

@@ lzss_hash_chain_compressor_top.f @@
src/lzsshc_pkg.sv
src/lzsshc_out.sv
src/lzss_hash_chain_compressor_top.sv
sim/tb_lzss_hash_chain_compressor_top.sv
